/* sv/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and field widths of the circular byte FIFO with peek.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 7;
	localparam int RLEN_W  = 11;
	localparam int FILL_W  = 10;

	typedef enum logic [KIND_W-1:0] {
		K_WRITE = 2'd0,
		K_READ  = 2'd1,
		K_PEEK  = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// result status, byte travels separately from the store
	typedef struct packed {
		logic              byte_valid;
		logic              write_accepted;
		logic              last_result;
		logic [FILL_W-1:0] fill_level;
	} res_t;

endpackage

`default_nettype wire

/* sv/brf_if.sv */
// ----------------------------------------------------------------------------
// brf_in_if / brf_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface brf_in_if import brf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [BYTE_W-1:0]  data_byte;
	logic [COUNT_W-1:0] count;
	logic               first_of_burst;

	modport source (output valid, kind, data_byte, count, first_of_burst, input ready);
	modport sink   (input valid, kind, data_byte, count, first_of_burst, output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_out;
	logic              byte_valid;
	logic              write_accepted;
	logic              last_result;
	logic [FILL_W-1:0] fill_level;

	modport source (output valid, byte_out, byte_valid, write_accepted, last_result,
		fill_level, input ready);
	modport sink   (input valid, byte_out, byte_valid, write_accepted, last_result,
		fill_level, output ready);
endinterface

`default_nettype wire

/* sv/byte_ring_fifo_with_peek_core.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_core
// Circular byte FIFO with configurable ring length, burst admission and peek.
// ----------------------------------------------------------------------------
// Write beat: taken while the result path can load; its result passes the
//   result stage, then the output register. Read/peek of n bytes: one store
//   read per cycle while the result path can load, no new request beat until
//   the last byte is issued. Empty or unused requests: one result, like a write.
// Reset clears pointers, fill and burst state; store contents stay undefined
//   (no clearing pass). A ring length write also empties the FIFO.
`default_nettype none

module byte_ring_fifo_with_peek_core import brf_pkg::*; #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_REQUEST = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [RLEN_W-1:0] cfg_wdata,
	brf_in_if.sink                 req,
	brf_out_if.source              rsp
);

	localparam int IDX_W    = $clog2(STORE_DEPTH);
	localparam int CW       = (RLEN_W > IDX_W + 1) ? RLEN_W : IDX_W + 1;
	localparam int SUM_W    = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
	localparam int NW       = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
	localparam int LAST_RST = ((STORE_DEPTH < 1024) ? STORE_DEPTH : 1024) - 1;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   last_q;
	logic [IDX_W-1:0]   rd_idx_q, wr_idx_q, pos_q, fill_q;
	logic               burst_q;
	logic [COUNT_W-1:0] rem_q, left_q;
	logic               consume_q;

	logic               accept, is_rd, is_wr, can_load, issue, load, req_ready;
	logic               store, burst_d, fit;
	logic [COUNT_W-1:0] rem_d, n_rd;
	logic [NW-1:0]      n_w;
	logic [IDX_W-1:0]   wr_nxt, pos_nxt, last_cfg;
	logic [CW-1:0]      cfg_ext;
	res_t               res, res_imm, res_iss;
	logic [BYTE_W-1:0]  mem_rdata;

	assign accept = req.valid && req_ready;
	assign is_wr  = (req.kind == K_WRITE);
	assign is_rd  = (req.kind == K_READ) || (req.kind == K_PEEK);

	assign wr_nxt  = (wr_idx_q == last_q) ? '0 : IDX_W'(wr_idx_q + 1'b1);
	assign pos_nxt = (pos_q == last_q) ? '0 : IDX_W'(pos_q + 1'b1);

	// free space strictly above count: fill + count <= len - 1
	assign fit = (SUM_W'(fill_q) + SUM_W'(req.count)) <= SUM_W'(last_q);

	always_comb begin
		store   = 1'b0;
		burst_d = burst_q;
		rem_d   = rem_q;
		if (req.first_of_burst) begin
			burst_d = 1'b0;
			rem_d   = '0;
			if (req.count != '0 && fit) begin
				burst_d = 1'b1;
				rem_d   = req.count - 1'b1;
				store   = 1'b1;
			end
		end else if (burst_q && rem_q != '0) begin
			rem_d = rem_q - 1'b1;
			store = 1'b1;
		end
		if (store && rem_d == '0) begin
			burst_d = 1'b0;
		end
	end

	always_comb begin
		n_w = NW'(req.count);
		if (n_w > NW'(MAX_REQUEST)) begin
			n_w = NW'(MAX_REQUEST);
		end
		if (n_w > NW'(fill_q)) begin
			n_w = NW'(fill_q);
		end
		n_rd = COUNT_W'(n_w);
	end

	assign cfg_ext = CW'(cfg_wdata);
	always_comb begin
		if (cfg_ext < CW'(2)) begin
			last_cfg = IDX_W'(1);
		end else if (cfg_ext > CW'(STORE_DEPTH)) begin
			last_cfg = IDX_W'(STORE_DEPTH - 1);
		end else begin
			last_cfg = IDX_W'(cfg_ext - 1'b1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_rd && n_rd != '0) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue && left_q == COUNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = can_load;
			ST_RUN:  issue     = can_load;
			default: begin
				req_ready = 1'b0;
				issue     = 1'b0;
			end
		endcase
	end

	assign req.ready = req_ready;

	always_comb begin
		res_imm.byte_valid     = 1'b0;
		res_imm.write_accepted = is_wr && store;
		res_imm.last_result    = 1'b1;
		res_imm.fill_level     = FILL_W'((is_wr && store) ? IDX_W'(fill_q + 1'b1) : fill_q);
		res_iss.byte_valid     = 1'b1;
		res_iss.write_accepted = 1'b0;
		res_iss.last_result    = (left_q == COUNT_W'(1));
		res_iss.fill_level     = FILL_W'(consume_q ? IDX_W'(fill_q - 1'b1) : fill_q);
	end

	assign load = (accept && !(is_rd && n_rd != '0)) || issue;
	assign res  = issue ? res_iss : res_imm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= IDX_W'(LAST_RST);
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			fill_q    <= '0;
			burst_q   <= 1'b0;
			rem_q     <= '0;
			left_q    <= '0;
			consume_q <= 1'b0;
			pos_q     <= '0;
		end else if (cfg_we) begin
			state_q  <= ST_IDLE;
			last_q   <= last_cfg;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			fill_q   <= '0;
			burst_q  <= 1'b0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_wr) begin
				burst_q <= burst_d;
				rem_q   <= rem_d;
				if (store) begin
					wr_idx_q <= wr_nxt;
					fill_q   <= IDX_W'(fill_q + 1'b1);
				end
			end
			if (accept && is_rd) begin
				left_q    <= n_rd;
				pos_q     <= rd_idx_q;
				consume_q <= (req.kind == K_READ);
			end
			if (issue) begin
				left_q <= left_q - 1'b1;
				pos_q  <= pos_nxt;
				if (consume_q) begin
					fill_q   <= IDX_W'(fill_q - 1'b1);
					rd_idx_q <= pos_nxt;
				end
			end
		end
	end

	brf_store #(
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && is_wr && store),
		.waddr (wr_idx_q),
		.wdata (req.data_byte),
		.re    (issue),
		.raddr (pos_q),
		.rdata (mem_rdata)
	);

	brf_res_pipe u_res_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.mem_rdata (mem_rdata),
		.can_load  (can_load),
		.rsp       (rsp)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= last_q)
		else $error("fill exceeds ring capacity");

	a_no_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !req_ready)
		else $error("request beat taken during read burst");

	a_issue_left: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> left_q != '0)
		else $error("store read with no bytes left");

	a_consume_fill: assert property (@(posedge clk) disable iff (!arst_n)
		issue && consume_q && !cfg_we |=> fill_q == IDX_W'($past(fill_q) - 1'b1))
		else $error("read did not drop fill");

endmodule

`default_nettype wire

/* sv/brf_store.sv */
// ----------------------------------------------------------------------------
// brf_store
// Byte store: one write port, one read port with enable, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_store import brf_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/brf_res_pipe.sv */
// ----------------------------------------------------------------------------
// brf_res_pipe
// Result stage aligned with the store read, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_res_pipe import brf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire res_t              res,
	input  wire logic [BYTE_W-1:0] mem_rdata,
	output logic                   can_load,
	brf_out_if.source              rsp
);

	logic              v_s1;
	res_t              res_s1;
	logic              out_v_q;
	res_t              out_res_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              s1_move;

	assign s1_move  = v_s1 && (!out_v_q || rsp.ready);
	assign can_load = !v_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res;
		end
		if (s1_move) begin
			out_res_q  <= res_s1;
			out_byte_q <= res_s1.byte_valid ? mem_rdata : '0;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.byte_out       = out_byte_q;
	assign rsp.byte_valid     = out_res_q.byte_valid;
	assign rsp.write_accepted = out_res_q.write_accepted;
	assign rsp.last_result    = out_res_q.last_result;
	assign rsp.fill_level     = out_res_q.fill_level;

endmodule

`default_nettype wire
